// ----- hdl/spq_pkg.sv -----
// Shared types, codes and the priority compare for the sorted priority queue.
// No dependencies; used by spq_ctrl, spq_datapath and sorted_priority_queue.
`timescale 1ns / 1ps

package spq_pkg;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_PEEK   = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// ordering modes: relation "stored R new" that keeps stored ahead
	localparam logic [1:0] MODE_LE = 2'd0;
	localparam logic [1:0] MODE_LT = 2'd1;
	localparam logic [1:0] MODE_GE = 2'd2;
	localparam logic [1:0] MODE_GT = 2'd3;

	// register byte addresses
	localparam logic [1:0] ADDR_ORDER_MODE = 2'd0;

	// one stored entry
	typedef struct packed {
		logic        [31:0] value;
		logic signed [31:0] prio;
	} entry_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic       load;       // latch the incoming item, restart the scan
		logic       ins_step;   // one scan/shift step of an insert
		logic       finish;     // register a result this cycle
		logic       take_head;  // result carries the head entry
		logic       pop;        // drop the head entry
		logic [1:0] code;       // result status
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic full;
		logic empty;
		logic ins_last;   // scan has passed every stored entry
	} stat_t;

	// does a stored priority stay ahead of a new one
	function automatic logic stays_ahead(input logic [1:0] mode,
		input logic signed [31:0] stored, input logic signed [31:0] incoming);
		logic r;
		case (mode)
			MODE_LE: r = (stored <= incoming);
			MODE_LT: r = (stored <  incoming);
			MODE_GE: r = (stored >= incoming);
			MODE_GT: r = (stored >  incoming);
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/spq_ctrl.sv -----
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg for the command and status structs and the codes.
`timescale 1ns / 1ps

module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         op,
	input  spq_pkg::stat_t     stat,
	output logic               busy,
	output spq_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_POP,
		ST_PEEK
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (op)
						spq_pkg::OP_INSERT: begin
							if (stat.full) begin
								cmd.finish = 1'b1;
								cmd.code   = spq_pkg::STATUS_FULL;
							end else begin
								state_d = ST_INSERT;
							end
						end
						spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
							if (stat.empty) begin
								cmd.finish = 1'b1;
								cmd.code   = spq_pkg::STATUS_EMPTY;
							end else begin
								state_d = (op == spq_pkg::OP_POP) ? ST_POP : ST_PEEK;
							end
						end
						default: begin
							cmd.finish = 1'b1;
							cmd.code   = spq_pkg::STATUS_OK;
						end
					endcase
				end
			end
			ST_INSERT: begin
				cmd.ins_step = 1'b1;
				if (stat.ins_last) begin
					cmd.finish = 1'b1;
					cmd.code   = spq_pkg::STATUS_OK;
					state_d    = ST_IDLE;
				end
			end
			ST_POP: begin
				cmd.finish    = 1'b1;
				cmd.take_head = 1'b1;
				cmd.pop       = 1'b1;
				cmd.code      = spq_pkg::STATUS_OK;
				state_d       = ST_IDLE;
			end
			ST_PEEK: begin
				cmd.finish    = 1'b1;
				cmd.take_head = 1'b1;
				cmd.code      = spq_pkg::STATUS_OK;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// no insert step may run once the scan is over
	a_ins_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT && stat.ins_last) |=> (state_q == ST_IDLE))
		else $error("insert did not end after last step");

	// a head read only follows an accepted pop or peek on a non-empty queue
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP || state_q == ST_PEEK) |-> !stat.empty)
		else $error("head read on empty queue");

	// a full insert never enters the scan
	a_full_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && op == spq_pkg::OP_INSERT && stat.full)
		|=> (state_q == ST_IDLE))
		else $error("insert into full queue started a scan");

endmodule

// ----- hdl/spq_datapath.sv -----
// Datapath of the sorted priority queue: entry memory kept as a ring,
// count, scan index, carry register and the result registers.
// Depends on spq_pkg for the entry type, the structs and the compare.
`timescale 1ns / 1ps

module spq_datapath #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::cmd_t       cmd,
	input  logic [1:0]          order_mode,
	input  logic [31:0]         in_value,
	input  logic signed [31:0]  in_prio,
	output spq_pkg::stat_t      stat,
	output logic                done,
	output logic [31:0]         head_value,
	output logic signed [31:0]  head_priority,
	output logic [1:0]          status,
	output logic                now_empty
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CAP_A = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	spq_pkg::entry_t mem [CAPACITY];

	spq_pkg::entry_t new_q, carry_q, rd_q, wr_data;
	logic [CW-1:0]   count_q, cnt_next, k_q, k_inc;
	logic [AW-1:0]   base_q, rd_addr, wr_addr;
	logic            found_q, wr_en, ahead;

	logic [31:0]        res_value_q;
	logic signed [31:0] res_prio_q;
	logic [1:0]         res_status_q;
	logic               res_empty_q, done_q;

	// logical index to ring address, wrapping at the capacity
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
		input logic [AW-1:0] idx);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, idx};
		if (sum >= CAP_A) begin
			sum = sum - CAP_A;
		end
		return sum[AW-1:0];
	endfunction

	assign k_inc = k_q + CW'(1);

	assign stat.full     = (count_q == CAP_C);
	assign stat.empty    = (count_q == '0);
	assign stat.ins_last = (k_q == count_q);

	assign ahead = !found_q && spq_pkg::stays_ahead(order_mode, rd_q.prio, new_q.prio);

	// read the next scan entry while inserting, the head otherwise
	assign rd_addr = cmd.ins_step ? phys(base_q, k_inc[AW-1:0]) : base_q;

	// write: the item or the carried entry lands at the scan position
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = phys(base_q, k_q[AW-1:0]);
		wr_data = found_q ? carry_q : new_q;
		if (cmd.ins_step) begin
			wr_en = stat.ins_last || !ahead;
		end
	end

	// count after this operation
	always_comb begin
		cnt_next = count_q;
		if (cmd.ins_step && stat.ins_last) begin
			cnt_next = count_q + CW'(1);
		end else if (cmd.pop) begin
			cnt_next = count_q - CW'(1);
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// control state: count, ring base, scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			base_q  <= '0;
			k_q     <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= cnt_next;
			done_q  <= cmd.finish;
			if (cmd.pop) begin
				base_q <= phys(base_q, AW'(1));
			end
			if (cmd.load) begin
				k_q     <= '0;
				found_q <= 1'b0;
			end else if (cmd.ins_step && !stat.ins_last) begin
				k_q <= k_inc;
				if (!ahead) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// payload: incoming item, carried entry, result fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_q.value <= in_value;
			new_q.prio  <= in_prio;
		end
		if (cmd.ins_step && !stat.ins_last && !ahead) begin
			carry_q <= rd_q;
		end
		if (cmd.finish) begin
			res_value_q  <= cmd.take_head ? rd_q.value : '0;
			res_prio_q   <= cmd.take_head ? rd_q.prio : '0;
			res_status_q <= cmd.code;
			res_empty_q  <= (cnt_next == '0);
		end
	end

	assign done          = done_q;
	assign head_value    = res_value_q;
	assign head_priority = res_prio_q;
	assign status        = res_status_q;
	assign now_empty     = res_empty_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_status_q == spq_pkg::STATUS_EMPTY) |-> res_empty_q)
		else $error("empty status without empty flag");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins_step && stat.ins_last) |-> !stat.full)
		else $error("insert grows a full queue");

endmodule

// ----- hdl/sorted_priority_queue.sv -----
// Sorted priority queue top level: order_mode register on the APB port,
// controller and datapath. Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-----------------------------------
//  item in   | start & !busy                  | op, item_value, item_priority
//  result    | done, one cycle, no stall      | head_value, head_priority,
//            |                                | status, now_empty
//  config    | psel & penable & pwrite        | paddr, pwdata (prdata on read)
//
// Result appears the cycle after the last work cycle: op 3, full insert and
// empty pop/peek finish in the cycle they are taken; pop and peek first wait
// on one registered memory read of the head; an insert runs a scan-and-shift
// pass through the entry memory, one entry per cycle, reading and writing it.
// busy is high while an item is in work. Reset clears the count and the ring
// base; no clearing pass is needed. Results cannot be held off.
`timescale 1ns / 1ps

module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [31:0]        item_value,
	input  logic signed [31:0] item_priority,
	output logic               done,
	output logic [31:0]        head_value,
	output logic signed [31:0] head_priority,
	output logic [1:0]         status,
	output logic               now_empty,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	spq_pkg::cmd_t  cmd;
	spq_pkg::stat_t stat;
	logic [1:0]     order_mode_q;

	assign pready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= spq_pkg::MODE_LE;
		end else if (psel && penable && pwrite && pready
			&& paddr == spq_pkg::ADDR_ORDER_MODE) begin
			order_mode_q <= pwdata[1:0];
		end
	end

	// register read back
	assign prdata = (paddr == spq_pkg::ADDR_ORDER_MODE) ? {30'd0, order_mode_q} : '0;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	spq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.order_mode    (order_mode_q),
		.in_value      (item_value),
		.in_prio       (item_priority),
		.stat          (stat),
		.done          (done),
		.head_value    (head_value),
		.head_priority (head_priority),
		.status        (status),
		.now_empty     (now_empty)
	);

endmodule

// ----- bench/sorted_priority_queue_test.sv -----
// Self-checking bench for sorted_priority_queue: directed and random insert, pop and peek
// items under every ordering mode, checked against an in-bench model of the sorted store.
// Depends on spq_pkg and sorted_priority_queue.
`timescale 1ns / 1ps

module sorted_priority_queue_test;

	localparam int CAPACITY = 16;
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE_CYCLES = CAPACITY + 4;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES = 11;
	localparam int PHASE_ITEMS = 148;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]         op;
		logic [31:0]        value;
		logic signed [31:0] prio;
	} request_t;

	typedef struct {
		logic [31:0]        value;
		logic signed [31:0] prio;
		logic [1:0]         code;
		logic               drained;
	} answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         op = spq_pkg::OP_INSERT;
	logic [31:0]        item_value = '0;
	logic signed [31:0] item_priority = '0;
	logic               done;
	logic [31:0]        head_value;
	logic signed [31:0] head_priority;
	logic [1:0]         status;
	logic               now_empty;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [1:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// bench state: items waiting to go in, answers due back, model of the store
	request_t pending_requests[$];
	answer_t  answers_due[$];
	spq_pkg::entry_t stored_entries[$];
	logic [1:0] mode_now = spq_pkg::MODE_LE;
	logic     item_taken = 1'b0;
	logic     steady = 1'b0;
	int       gap_left = 0;
	int       fail_count = 0;
	int       quiet_cycles = 0;
	answer_t  want;
	request_t next_rq;

	sorted_priority_queue #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.item_value(item_value),
		.item_priority(item_priority),
		.done(done),
		.head_value(head_value),
		.head_priority(head_priority),
		.status(status),
		.now_empty(now_empty),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// does a held entry stay ahead of the incoming one under the current mode
	function automatic logic keeps_place(input logic signed [31:0] held,
		input logic signed [31:0] incoming);
		logic lower;
		logic tie;
		lower = held < incoming;
		tie = held == incoming;
		case (mode_now)
			spq_pkg::MODE_LE: return lower | tie;
			spq_pkg::MODE_LT: return lower;
			spq_pkg::MODE_GE: return !lower;
			default: return !lower && !tie;
		endcase
	endfunction

	// apply one item to the model store and work out its answer
	function automatic answer_t apply_request(input request_t rq);
		answer_t a;
		spq_pkg::entry_t fresh;
		int slot;
		a = '{value: '0, prio: '0, code: spq_pkg::STATUS_OK, drained: 1'b0};
		case (rq.op)
			spq_pkg::OP_INSERT: begin
				if (stored_entries.size() >= CAPACITY) begin
					a.code = spq_pkg::STATUS_FULL;
				end else begin
					slot = 0;
					while (slot < stored_entries.size()
						&& keeps_place(stored_entries[slot].prio, rq.prio))
						slot++;
					fresh.value = rq.value;
					fresh.prio = rq.prio;
					stored_entries.insert(slot, fresh);
				end
			end
			spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
				if (stored_entries.size() == 0) begin
					a.code = spq_pkg::STATUS_EMPTY;
				end else begin
					a.value = stored_entries[0].value;
					a.prio = stored_entries[0].prio;
					if (rq.op == spq_pkg::OP_POP)
						void'(stored_entries.pop_front());
				end
			end
			default: ;
		endcase
		a.drained = (stored_entries.size() == 0);
		return a;
	endfunction

	// random item: 3 in 100 use the unused code; inserts take the rolls from 3 up to fill_bias
	function automatic request_t random_request(input int fill_bias);
		request_t rq;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			rq.op = OP_UNUSED;
		else if (roll < fill_bias)
			rq.op = spq_pkg::OP_INSERT;
		else if ($urandom_range(0, 3) == 0)
			rq.op = spq_pkg::OP_PEEK;
		else
			rq.op = spq_pkg::OP_POP;
		rq.value = $urandom;
		// narrow range for plenty of ties, full range, and the extremes
		roll = $urandom_range(0, 9);
		if (roll < 5) begin
			rq.prio = $signed($urandom_range(0, 8)) - 4;
		end else if (roll < 8) begin
			rq.prio = $urandom;
		end else begin
			case ($urandom_range(0, 4))
				0: rq.prio = 32'sh8000_0000;
				1: rq.prio = 32'sh7FFF_FFFF;
				2: rq.prio = 0;
				3: rq.prio = -1;
				default: rq.prio = 1;
			endcase
		end
		return rq;
	endfunction

	// gap before the next item: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	task automatic add_item(input logic [1:0] code, input logic [31:0] value,
		input logic signed [31:0] prio);
		pending_requests.push_back('{code, value, prio});
	endtask

	// write order_mode over apb, then read it back
	task automatic set_order(input logic [1:0] mode);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= spq_pkg::ADDR_ORDER_MODE;
		pwdata <= {30'd0, mode};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mode_now = mode;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[1:0] !== mode) begin
			$error("prdata: expected %0d, got %0d", mode, prdata[1:0]);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// let every outstanding item finish, then allow the block to settle
	task automatic wait_quiet();
		while (pending_requests.size() != 0 || answers_due.size() != 0 || start)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver: next item presented on the falling edge once the last one is taken
	always @(negedge clk) begin
		if (!start || item_taken) begin
			item_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				next_rq = pending_requests.pop_front();
				op <= next_rq.op;
				item_value <= next_rq.value;
				item_priority <= next_rq.prio;
				start <= 1'b1;
				gap_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, log accepted items, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (answers_due.size() == 0) begin
					$error("result with no item outstanding");
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					if (head_value !== want.value) begin
						$error("head_value: expected %h, got %h", want.value, head_value);
						fail_count++;
					end
					if (head_priority !== want.prio) begin
						$error("head_priority: expected %0d, got %0d", want.prio,
							head_priority);
						fail_count++;
					end
					if (status !== want.code) begin
						$error("status: expected %0d, got %0d", want.code, status);
						fail_count++;
					end
					if (now_empty !== want.drained) begin
						$error("now_empty: expected %0d, got %0d", want.drained, now_empty);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				answers_due.push_back(apply_request('{op, item_value, item_priority}));
				item_taken = 1'b1;
			end
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// stimulus: reset, directed items, then random phases over the ordering modes
	initial begin
		int phase;
		int n;
		int fill_bias;
		logic [1:0] mode_plan[4];
		mode_plan = '{spq_pkg::MODE_GT, spq_pkg::MODE_LT, spq_pkg::MODE_GE,
			spq_pkg::MODE_LE};
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_order(spq_pkg::MODE_LE);

		// empty-queue reads and the unused code
		add_item(spq_pkg::OP_POP, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
		add_item(spq_pkg::OP_PEEK, 32'h0, 32'sh8000_0000);
		add_item(OP_UNUSED, 32'hFFFF_FFFF, -1);
		// fill to capacity with extremes and ties
		add_item(spq_pkg::OP_INSERT, 32'h0000_0000, 32'sh8000_0000);
		add_item(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
		add_item(spq_pkg::OP_INSERT, 32'hA5A5_0002, 0);
		add_item(spq_pkg::OP_INSERT, 32'hA5A5_0003, -1);
		add_item(spq_pkg::OP_INSERT, 32'hA5A5_0004, 0);
		add_item(spq_pkg::OP_INSERT, 32'hA5A5_0005, 1);
		add_item(spq_pkg::OP_INSERT, 32'hA5A5_0006, 0);
		add_item(spq_pkg::OP_INSERT, 32'h5A5A_0007, 32'sh8000_0000);
		add_item(spq_pkg::OP_INSERT, 32'h5A5A_0008, 32'sh7FFF_FFFF);
		add_item(spq_pkg::OP_INSERT, 32'h5A5A_0009, 5);
		add_item(spq_pkg::OP_INSERT, 32'h5A5A_000A, -5);
		add_item(spq_pkg::OP_INSERT, 32'h5A5A_000B, 3);
		add_item(spq_pkg::OP_INSERT, 32'h5A5A_000C, 3);
		add_item(spq_pkg::OP_INSERT, 32'h5A5A_000D, 100);
		add_item(spq_pkg::OP_INSERT, 32'h5A5A_000E, -100);
		add_item(spq_pkg::OP_INSERT, 32'h5A5A_000F, 7);
		// refused insert, then reads on a full queue
		add_item(spq_pkg::OP_INSERT, 32'hDEAD_BEEF, 0);
		add_item(spq_pkg::OP_PEEK, 32'h0, 0);
		add_item(OP_UNUSED, 32'h0, 0);
		add_item(spq_pkg::OP_POP, 32'h0, 0);
		add_item(spq_pkg::OP_POP, 32'h0, 0);
		wait_quiet();

		// random phases; the bench holds off between phases until all results are in
		for (phase = 0; phase < PHASES; phase++) begin
			set_order(phase < 4 ? mode_plan[phase] : 2'($urandom_range(0, 3)));
			steady = (phase == 1) || ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 25 == 0) begin
					case ($urandom_range(0, 2))
						0: fill_bias = 80;
						1: fill_bias = 25;
						default: fill_bias = 52;
					endcase
				end
				pending_requests.push_back(random_request(fill_bias));
			end
			wait_quiet();
		end

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
